// File: hdl/fplw_pkg.sv
// shared constants, a type and an address helper for the four-level page walk
package fplw_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int ENTRY_W   = 64;
  localparam int PA_W      = 52;
  localparam int PADDR_W   = 4;

  // register index taken from paddr[3]
  localparam logic REG_DIR_BASE = 1'b0;

  localparam logic KIND_WRITE     = 1'b0;
  localparam logic KIND_TRANSLATE = 1'b1;

  localparam logic [1:0] PAGE_4K = 2'd0;
  localparam logic [1:0] PAGE_2M = 2'd1;
  localparam logic [1:0] PAGE_1G = 2'd2;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  typedef logic [ADDR_W-1:0] mem_addr_t;

  // word index of (base + 8 * idx) modulo the memory depth; base_w is base / 8
  function automatic mem_addr_t entry_addr(input logic [48:0] base_w, input logic [8:0] idx);
    logic [48:0] sum;
    sum = base_w + {40'b0, idx};
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// File: hdl/fplw_ram.sv
// generic single-port ram with registered read
module fplw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/four_level_page_table_walk.sv
// four-level page walk: table memory, walk sequencer, apb register and result register
//
//   channel   dir  handshake               payload
//   in_       in   in_valid / in_stall     kind, table_index, table_word, virt_addr
//   out_      out  out_valid / out_stall   phys_addr, fault, page_kind
//   apb       in   psel/penable/pready     paddr, pwdata, prdata (dir_base)
//
// a write item is written to the table as it is accepted; a translate item reads one table
// entry per level (one to four levels), one at a time through the single ram port and its
// registered read, then loads the result register when the walk ends and the register is free.
// after reset a clearing pass zeroes all MEM_WORDS (4096) table words, with in_stall high.
// a result held by out_stall lets write items through but holds the next walk at its end.
module four_level_page_table_walk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [11:0]                   in_table_index,
  input  logic [63:0]                   in_table_word,
  input  logic [47:0]                   in_virt_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [51:0]                   out_phys_addr,
  output logic                          out_fault,
  output logic [1:0]                    out_page_kind,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fplw_pkg::PADDR_W-1:0]  paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [1:0]                 lvl_r, lvl_nxt;
  fplw_pkg::mem_addr_t        clr_cnt_r, clr_cnt_nxt;
  fplw_pkg::mem_addr_t        rd_addr_r, rd_addr_nxt;
  logic [38:0]                va_r, va_nxt;
  logic [fplw_pkg::PA_W-1:0]  dir_base_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [fplw_pkg::PA_W-1:0]  out_pa_r, out_pa_nxt;
  logic                       out_fault_r, out_fault_nxt;
  logic [1:0]                 out_kind_r, out_kind_nxt;

  logic                       ram_we;
  fplw_pkg::mem_addr_t        ram_addr;
  logic [63:0]                ram_wdata;
  logic [63:0]                entry;

  logic                       in_acc;
  logic                       out_free;
  logic                       walk_done;
  logic [fplw_pkg::PA_W-1:0]  res_pa;
  logic                       res_fault;
  logic [1:0]                 res_kind;
  logic [8:0]                 next_idx;
  logic                       cfg_wr;

  fplw_ram #(
    .WIDTH (fplw_pkg::ENTRY_W),
    .DEPTH (fplw_pkg::MEM_WORDS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (entry)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // evaluate the entry returned for the current level
  always_comb begin
    walk_done = 1'b0;
    res_pa    = '0;
    res_fault = 1'b0;
    res_kind  = fplw_pkg::PAGE_4K;
    next_idx  = va_r[38:30];
    unique case (lvl_r)
      2'd0: begin
        next_idx = va_r[38:30];
        if (!entry[fplw_pkg::BIT_PRESENT]) begin
          walk_done = 1'b1;
          res_fault = 1'b1;
        end
      end
      2'd1: begin
        next_idx = va_r[29:21];
        if (!entry[fplw_pkg::BIT_PRESENT]) begin
          walk_done = 1'b1;
          res_fault = 1'b1;
        end else if (entry[fplw_pkg::BIT_LARGE]) begin
          walk_done = 1'b1;
          res_pa    = {entry[51:30], va_r[29:0]};
          res_kind  = fplw_pkg::PAGE_1G;
        end
      end
      2'd2: begin
        next_idx = va_r[20:12];
        if (!entry[fplw_pkg::BIT_PRESENT]) begin
          walk_done = 1'b1;
          res_fault = 1'b1;
        end else if (entry[fplw_pkg::BIT_LARGE]) begin
          walk_done = 1'b1;
          res_pa    = {entry[51:21], va_r[20:0]};
          res_kind  = fplw_pkg::PAGE_2M;
        end
      end
      2'd3: begin
        walk_done = 1'b1;
        if (entry[51:12] == 40'd0) begin
          res_fault = 1'b1;
        end else begin
          res_pa = {entry[51:12], va_r[11:0]};
        end
      end
      default: begin
        walk_done = 1'b1;
        res_fault = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    clr_cnt_nxt   = clr_cnt_r;
    rd_addr_nxt   = rd_addr_r;
    va_nxt        = va_r;
    ram_we        = 1'b0;
    ram_addr      = rd_addr_r;
    ram_wdata     = in_table_word;
    out_valid_nxt = out_valid_r && out_stall;
    out_pa_nxt    = out_pa_r;
    out_fault_nxt = out_fault_r;
    out_kind_nxt  = out_kind_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + fplw_pkg::mem_addr_t'(1);
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == fplw_pkg::KIND_WRITE) begin
            ram_we   = 1'b1;
            ram_addr = fplw_pkg::mem_addr_t'(in_table_index);
          end else begin
            ram_addr    = fplw_pkg::entry_addr({dir_base_r[51:4], 1'b0}, in_virt_addr[47:39]);
            rd_addr_nxt = ram_addr;
            va_nxt      = in_virt_addr[38:0];
            lvl_nxt     = 2'd0;
            state_nxt   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          // result register still full: re-read the same entry and wait
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_pa_nxt    = res_pa;
            out_fault_nxt = res_fault;
            out_kind_nxt  = res_kind;
            state_nxt     = ST_IDLE;
          end
        end else begin
          ram_addr    = fplw_pkg::entry_addr({entry[51:12], 9'b0}, next_idx);
          rd_addr_nxt = ram_addr;
          lvl_nxt     = lvl_r + 2'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      lvl_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    va_r        <= va_nxt;
    out_pa_r    <= out_pa_nxt;
    out_fault_r <= out_fault_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_base_r <= '0;
    end else if (cfg_wr && (paddr[3] == fplw_pkg::REG_DIR_BASE)) begin
      dir_base_r <= pwdata[51:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3] == fplw_pkg::REG_DIR_BASE) begin
      prdata = {12'b0, dir_base_r};
    end
  end

  assign out_valid     = out_valid_r;
  assign out_phys_addr = out_pa_r;
  assign out_fault     = out_fault_r;
  assign out_page_kind = out_kind_r;

`ifndef SYNTH
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == fplw_pkg::KIND_TRANSLATE) |=> (state_r == ST_WALK) && (lvl_r == 2'd0))
    else $error("translate item did not start a walk at the top level");

  a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && walk_done && out_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished walk did not load the result register");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall && !out_valid_r)
    else $error("input taken or result shown during clearing pass");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fault_r |-> (out_pa_r == '0) && (out_kind_r == fplw_pkg::PAGE_4K))
    else $error("faulting result carries nonzero address or page kind");
`endif

endmodule
